// ----- rtl/aabb_any_overlap_query_assert.svh -----
// Assertion macros used by aabb_any_overlap_query.sv.
`ifndef AABB_ANY_OVERLAP_QUERY_ASSERT_SVH
`define AABB_ANY_OVERLAP_QUERY_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define AOQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aoq assertion failed");

// next-cycle implication, disabled while in reset
`define AOQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aoq assertion failed");

`endif

// ----- rtl/aoq_pkg.sv -----
package aoq_pkg;

  localparam int unsigned CFG_W   = 7;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned FIELD_W = 32;

  localparam int unsigned MAX_OBSTACLES_DEF = 64;
  localparam int unsigned COORD_BITS_DEF    = 32;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } aoq_state_e;

endpackage

// ----- rtl/aoq_store.sv -----
module aoq_store
  import aoq_pkg::*;
#(
  parameter int unsigned DEPTH  = MAX_OBSTACLES_DEF,
  parameter int unsigned IDX_W  = 6,
  parameter int unsigned DATA_W = 6 * COORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/aoq_cmp.sv -----
module aoq_cmp
  import aoq_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic [6*COORD_BITS-1:0] probe_i,
  input  logic [6*COORD_BITS-1:0] obst_i,
  output logic                    touch_o
);

  // box layout: min x,y,z in the low three lanes, max x,y,z in the upper three
  logic [2:0] axis_ok;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      axis_ok[k] =
        ($signed(probe_i[k*COORD_BITS +: COORD_BITS]) <=
         $signed(obst_i[(3+k)*COORD_BITS +: COORD_BITS])) &&
        ($signed(probe_i[(3+k)*COORD_BITS +: COORD_BITS]) >=
         $signed(obst_i[k*COORD_BITS +: COORD_BITS]));
    end
  end

  assign touch_o = &axis_ok;

endmodule

// ----- rtl/aabb_any_overlap_query.sv -----
// 3D box overlap search against a table of obstacle boxes.
// Input: command style. A transaction is taken at a rising edge with start
// high and busy low. mode_i = load writes the box into slot_i (slots at or
// above MAX_OBSTACLES are dropped) and gives no result. mode_i = query tests
// the box against the first min(obstacle_count, MAX_OBSTACLES) stored boxes.
// Result: hit_o and batch_end_o are valid for exactly one cycle while done_o
// is high. The receiver cannot stall; each result must be taken when shown.
// Config: obstacle_count is written on cfg_data_i when cfg_valid_i and
// cfg_ready_o are high; ready is high whenever the block is idle.
// Timing: a query keeps busy high while it reads the counted boxes, one
// table read per cycle through the store's read port, each box compared
// in the cycle after its read, and stops on the first hit; done_o rises at
// the same edge at which busy falls. A query with a count of zero answers
// the cycle after acceptance without going busy.
// Reset: clears the count and the control state; table contents stay
// undefined until each slot is loaded.
module aabb_any_overlap_query
  import aoq_pkg::*;
#(
  parameter int unsigned MAX_OBSTACLES = MAX_OBSTACLES_DEF,
  parameter int unsigned COORD_BITS    = COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [FIELD_W-1:0] min_x_i,
  input  logic [FIELD_W-1:0] min_y_i,
  input  logic [FIELD_W-1:0] min_z_i,
  input  logic [FIELD_W-1:0] max_x_i,
  input  logic [FIELD_W-1:0] max_y_i,
  input  logic [FIELD_W-1:0] max_z_i,
  input  logic               last_link_i,
  output logic               done_o,
  output logic               hit_o,
  output logic               batch_end_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_W-1:0]   cfg_data_i
);

  localparam int unsigned IdxW   = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int unsigned LimW0  = $clog2(MAX_OBSTACLES + 1);
  localparam int unsigned CntW   = (LimW0 > CFG_W) ? LimW0 : CFG_W;
  localparam int unsigned BoxW   = 6 * COORD_BITS;

  aoq_state_e state_q, state_d;

  logic [CFG_W-1:0] cnt_cfg_q;
  logic [CntW-1:0]  lim_q, lim_d, lim_now;
  logic [CntW-1:0]  addr_q, addr_d;
  logic             all_iss_q, all_iss_d;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;
  logic [BoxW-1:0]  probe_q, probe_d;
  logic             done_q, done_d;
  logic             hit_q, hit_d;
  logic             batch_q, batch_d;

  logic             accept;
  logic             slot_ok;
  logic [BoxW-1:0]  in_box;
  logic             rd_en;
  logic [BoxW-1:0]  obst_box;
  logic             touch;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);

  assign in_box = {max_z_i[COORD_BITS-1:0], max_y_i[COORD_BITS-1:0],
                   max_x_i[COORD_BITS-1:0], min_z_i[COORD_BITS-1:0],
                   min_y_i[COORD_BITS-1:0], min_x_i[COORD_BITS-1:0]};

  assign slot_ok = (CntW'(slot_i) < CntW'(MAX_OBSTACLES));
  assign lim_now = (CntW'(cnt_cfg_q) > CntW'(MAX_OBSTACLES)) ?
                   CntW'(MAX_OBSTACLES) : CntW'(cnt_cfg_q);

  aoq_store #(
    .DEPTH  (MAX_OBSTACLES),
    .IDX_W  (IdxW),
    .DATA_W (BoxW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && (mode_i == MODE_LOAD) && slot_ok),
    .waddr_i (IdxW'(slot_i)),
    .wdata_i (in_box),
    .re_i    (rd_en),
    .raddr_i (addr_q[IdxW-1:0]),
    .rdata_o (obst_box)
  );

  aoq_cmp #(
    .COORD_BITS (COORD_BITS)
  ) u_cmp (
    .probe_i (probe_q),
    .obst_i  (obst_box),
    .touch_o (touch)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_cfg_q <= '0;
      all_iss_q <= 1'b0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      all_iss_q <= all_iss_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cnt_cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q       <= lim_d;
    addr_q      <= addr_d;
    pend_last_q <= pend_last_d;
    probe_q     <= probe_d;
    hit_q       <= hit_d;
    batch_q     <= batch_d;
  end

  always_comb begin
    state_d     = state_q;
    lim_d       = lim_q;
    addr_d      = addr_q;
    all_iss_d   = all_iss_q;
    pend_d      = 1'b0;
    pend_last_d = 1'b0;
    probe_d     = probe_q;
    done_d      = 1'b0;
    hit_d       = hit_q;
    batch_d     = batch_q;
    rd_en       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept && (mode_i == MODE_QUERY)) begin
          probe_d = in_box;
          batch_d = last_link_i;
          lim_d   = lim_now;
          if (lim_now == '0) begin
            done_d = 1'b1;
            hit_d  = 1'b0;
          end else begin
            addr_d    = '0;
            all_iss_d = 1'b0;
            state_d   = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        // read slot addr_q this cycle, compare the slot read last cycle
        rd_en = !all_iss_q;
        if (rd_en) begin
          pend_d      = 1'b1;
          pend_last_d = (addr_q == lim_q - CntW'(1));
          all_iss_d   = (addr_q == lim_q - CntW'(1));
          addr_d      = addr_q + CntW'(1);
        end
        if (pend_q && touch) begin
          done_d  = 1'b1;
          hit_d   = 1'b1;
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end else if (pend_q && pend_last_q) begin
          done_d  = 1'b1;
          hit_d   = 1'b0;
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign done_o      = done_q;
  assign hit_o       = hit_q;
  assign batch_end_o = batch_q;

`include "aabb_any_overlap_query_assert.svh"

  `AOQ_ASSERT_NXT(a_query_progress, accept && (mode_i == MODE_QUERY), busy || done_o)
  `AOQ_ASSERT_NXT(a_hit_reported, (state_q == ST_RUN) && pend_q && touch, done_o && hit_o)
  `AOQ_ASSERT_IMP(a_read_in_range, rd_en, addr_q < lim_q)
  `AOQ_ASSERT_IMP(a_run_nonzero, busy, lim_q != '0)
  `AOQ_ASSERT_NXT(a_load_no_result, accept && (mode_i == MODE_LOAD), !done_o && !busy)

endmodule
